@@ rtl/ptc_pkg.sv @@
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the chained 4x4 point transform block.
// ----------------------------------------------------------------------------
package ptc_pkg;

    // default parameter values
    localparam int MAX_MATS_DEF  = 8;
    localparam int FRAC_BITS_DEF = 16;

    // field widths
    localparam int CFG_W   = 4;
    localparam int COORD_W = 32;
    localparam int ELEM_W  = 4;      // element index within one matrix
    localparam int IN_W    = 168;    // input tdata, padded to bytes
    localparam int OUT_W   = 128;

    // input item kinds (tuser)
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_POINT = 1'b1;

    // last element of a matrix, row 3 column 3
    localparam logic [ELEM_W-1:0] LAST_ELEM = 4'hF;
    localparam logic [1:0]        LAST_COL  = 2'd3;
    localparam logic [1:0]        LAST_ROW  = 2'd3;

    // point vector, index 0 is x in the lowest bits
    typedef logic [3:0][COORD_W-1:0] t_point;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WAIT = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    // tag that travels with a matrix element through the MAC pipeline
    typedef struct packed {
        logic              vld;
        logic [ELEM_W-1:0] elem;
    } t_mac_ctl;

endpackage

@@ rtl/ptc_matrix_mem.sv @@
// ----------------------------------------------------------------------------
// ptc_matrix_mem
// Matrix element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptc_matrix_mem #(
    parameter int AW = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);
    import ptc_pkg::*;

    localparam int DEPTH = 1 << AW;

    logic [COORD_W-1:0] r_mem [DEPTH];
    logic [COORD_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ptc_mac.sv @@
// ----------------------------------------------------------------------------
// ptc_mac
// Shared multiply-accumulate lane: one matrix element per cycle, row results
// floored, saturated and collected into the next point.
// ----------------------------------------------------------------------------
module ptc_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ptc_pkg::t_point   i_pt,
    input  ptc_pkg::t_mac_ctl i_ctl,
    input  logic [31:0]       i_rdata,
    output ptc_pkg::t_point   o_pt,
    output logic              o_pass_done
);
    import ptc_pkg::*;

    localparam int PW  = 2 * COORD_W;   // product width
    localparam int ACW = PW + 2;        // three products plus offset

    t_point                    r_pt;
    logic [COORD_W-1:0]        r_nxt [3];
    t_mac_ctl                  r_s2;
    logic signed [PW-1:0]      r_prod;
    logic signed [ACW-1:0]     r_acc;

    logic signed [COORD_W-1:0] w_m;
    logic signed [COORD_W-1:0] w_c;
    logic signed [PW-1:0]      w_prod;
    logic signed [ACW-1:0]     w_sum;
    logic signed [ACW-1:0]     w_shr;
    logic [ACW-1:COORD_W-1]    w_hi;
    logic [COORD_W-1:0]        w_sat;
    logic [1:0]                w_row;
    logic [1:0]                w_col;

    // stage 1: multiply element by coordinate, or align the offset column
    assign w_m = $signed(i_rdata);
    assign w_c = $signed(r_pt[i_ctl.elem[1:0]]);

    always_comb begin
        if (i_ctl.elem[1:0] == LAST_COL) begin
            w_prod = PW'(w_m) <<< FRAC_BITS;
        end else begin
            w_prod = w_m * w_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.vld <= 1'b0;
        end else begin
            r_s2.vld <= i_ctl.vld;
        end
        r_s2.elem <= i_ctl.elem;
        r_prod    <= w_prod;
    end

    // stage 2: accumulate, floor shift, saturate
    assign w_row = r_s2.elem[3:2];
    assign w_col = r_s2.elem[1:0];
    assign w_sum = ((w_col == 2'd0) ? ACW'(0) : r_acc) + ACW'(r_prod);
    assign w_shr = w_sum >>> FRAC_BITS;
    assign w_hi  = w_shr[ACW-1:COORD_W-1];

    always_comb begin
        if ((&w_hi) || !(|w_hi)) begin
            w_sat = w_shr[COORD_W-1:0];
        end else if (w_shr[ACW-1]) begin
            w_sat = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2.vld) begin
            r_acc <= w_sum;
        end
    end

    // row results; the last row completes the pass and updates the point
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pt <= i_pt;
        end else if (r_s2.vld && w_col == LAST_COL) begin
            if (w_row == LAST_ROW) begin
                r_pt <= {w_sat, r_nxt[2], r_nxt[1], r_nxt[0]};
            end else begin
                r_nxt[w_row] <= w_sat;
            end
        end
    end

    assign o_pt        = r_pt;
    assign o_pass_done = r_s2.vld && (r_s2.elem == LAST_ELEM);

endmodule

@@ rtl/point_transform_chain.sv @@
// ----------------------------------------------------------------------------
// point_transform_chain
// Chained 4x4 homogeneous transform of points in signed fixed point.
// ----------------------------------------------------------------------------
// A write request (tuser 0) stores one matrix element. A point request
// (tuser 1) runs through matrices 0 to chain_length-1; each matrix pass
// reads its 16 elements from the single read port of the matrix store,
// one per cycle, into one shared 32x32 multiplier, then waits for the
// multiply and accumulate stages to drain before the next pass uses the
// new point. The chain length is capped at MAX_MATS; with a chain length
// of zero the point returns unchanged. The result sits in an output
// register, so a new request is taken while it waits to be read.
// ----------------------------------------------------------------------------
module point_transform_chain #(
    parameter int MAX_MATS  = ptc_pkg::MAX_MATS_DEF,
    parameter int FRAC_BITS = ptc_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration: chain_length
    input  logic                       i_cfg_we,
    input  logic [ptc_pkg::CFG_W-1:0]  i_cfg_wdata,
    // input stream
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // mat_index[2:0], row[4:3], col[6:5], elem_value[38:7], px[70:39],
    // py[102:71], pz[134:103], pw[166:135], zero pad[167]
    input  logic [ptc_pkg::IN_W-1:0]   i_s_axis_tdata,
    // func[0]
    input  logic [0:0]                 i_s_axis_tuser,
    // output stream
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // qx[31:0], qy[63:32], qz[95:64], qw[127:96]
    output logic [ptc_pkg::OUT_W-1:0]  o_m_axis_tdata
);
    import ptc_pkg::*;

    localparam int AW = $clog2(MAX_MATS * 16);
    localparam int CW = $clog2(MAX_MATS + 1);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_mat, n_mat;
    logic [ELEM_W-1:0]  r_elem, n_elem;
    logic [CFG_W-1:0]   r_cfg;
    t_mac_ctl           r_s1;
    logic               r_out_vld;
    logic [OUT_W-1:0]   r_out_data;

    logic               w_accept;
    logic               w_we;
    logic               w_load;
    logic               w_pass_done;
    logic               w_out_take;
    logic [CW-1:0]      w_n;
    logic [AW-1:0]      w_waddr;
    logic [AW-1:0]      w_raddr;
    logic [31:0]        w_rdata;
    t_point             w_in_pt;
    t_point             w_pt;

    // request decode; store address is mat_index, row, col from high to low
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_we     = w_accept && (i_s_axis_tuser[0] == FUNC_WRITE)
                      && (int'(i_s_axis_tdata[2:0]) < MAX_MATS);
    assign w_load   = w_accept && (i_s_axis_tuser[0] == FUNC_POINT);
    assign w_waddr  = AW'({i_s_axis_tdata[2:0], i_s_axis_tdata[4:3],
                           i_s_axis_tdata[6:5]});
    assign w_in_pt  = t_point'(i_s_axis_tdata[166:39]);
    assign w_raddr  = AW'({r_mat, r_elem});

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // chain length capped at the store size
    always_comb begin
        if (int'(r_cfg) > MAX_MATS) begin
            w_n = CW'(MAX_MATS);
        end else begin
            w_n = CW'(r_cfg);
        end
    end

    ptc_matrix_mem #(
        .AW(AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_s_axis_tdata[38:7]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ptc_mac #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_pt        (w_in_pt),
        .i_ctl       (r_s1),
        .i_rdata     (w_rdata),
        .o_pt        (w_pt),
        .o_pass_done (w_pass_done)
    );

    assign w_out_take = (r_state == S_OUT) && (!r_out_vld || i_m_axis_tready);

    // sequencer: issue reads for one matrix, wait for the pass to drain
    always_comb begin
        n_state = r_state;
        n_mat   = r_mat;
        n_elem  = r_elem;
        unique case (r_state)
            S_IDLE: begin
                n_mat  = '0;
                n_elem = '0;
                if (w_load) begin
                    n_state = (w_n == '0) ? S_OUT : S_RUN;
                end
            end
            S_RUN: begin
                n_elem = r_elem + 1'b1;
                if (r_elem == LAST_ELEM) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_pass_done) begin
                    if ({1'b0, r_mat} + 1'b1 == {1'b0, w_n}) begin
                        n_state = S_OUT;
                    end else begin
                        n_mat   = r_mat + 1'b1;
                        n_state = S_RUN;
                    end
                end
            end
            S_OUT: begin
                if (w_out_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mat    <= '0;
            r_elem   <= '0;
            r_s1.vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mat    <= n_mat;
            r_elem   <= n_elem;
            r_s1.vld <= (r_state == S_RUN);
        end
        r_s1.elem <= r_elem;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_take) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (w_out_take) begin
            r_out_data <= OUT_W'(w_pt);
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    // no store write while a pass is reading the store
    a_no_write_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !w_we)
        else $error("matrix store written during a pass");

    // MAC pipeline is empty whenever new requests are taken
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_s1.vld && !w_pass_done))
        else $error("MAC pipeline busy while idle");

    // a pass completes only while the sequencer waits for it
    a_pass_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pass_done |-> (r_state == S_WAIT))
        else $error("pass completion outside wait state");

    // reads never go past the active chain
    a_mat_in_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_mat < w_n))
        else $error("matrix index beyond chain length");
`endif

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the chained 4x4 point transform block. Matrix
// element writes and point requests are streamed in with random bursts and
// gaps. A shadow copy of the matrix store and of chain_length predicts every
// transformed point, and each result is compared field by field. The result
// side stalls on its own changing pattern, with one long hold-off that
// backs the block up.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ptc_pkg::*;

    localparam int NUM_MATS     = MAX_MATS_DEF;
    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 10;
    localparam int END_CYCLES   = 18 * MAX_MATS_DEF + 20;
    localparam int HOLD_CYCLES  = 500;
    localparam int RANDOM_ITEMS = 750;
    localparam int unsigned LIMIT_CYCLES = 1_000_000;

    localparam logic signed [67:0] SAT_HI = 68'sh0_7FFF_FFFF;
    localparam logic signed [67:0] SAT_LO = -68'sh0_8000_0000;

    // DUT signals
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata   = '0;
    logic [0:0]           s_tuser   = FUNC_WRITE;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;

    // shadow state for prediction
    logic signed [31:0]   matrix_shadow [NUM_MATS][4][4];
    logic [CFG_W-1:0]     chain_len_shadow = '0;
    t_point               pending_points [$];

    // bookkeeping
    int                   mismatch_count  = 0;
    int                   results_checked = 0;
    int                   writes_sent     = 0;
    int                   points_sent     = 0;
    int                   burst_left      = 0;
    int unsigned          cycle_count     = 0;
    int                   hold_seq        = 0;
    string                field_tag       = "xyzw";

    point_transform_chain DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    // clock, 10 ns period
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // one output row of one matrix pass: exact sum, floor shift, saturate
    function automatic logic [31:0] row_result(input int m, input int r, input t_point p);
        logic signed [67:0] acc;
        logic signed [67:0] a;
        logic signed [67:0] b;
        acc = matrix_shadow[m][r][3];
        acc = acc <<< FRAC;
        for (int k = 0; k < 3; k++) begin
            a = matrix_shadow[m][r][k];
            b = $signed(p[k]);
            acc = acc + a * b;
        end
        acc = acc >>> FRAC;
        if (acc > SAT_HI)
            return 32'h7FFF_FFFF;
        if (acc < SAT_LO)
            return 32'h8000_0000;
        return acc[31:0];
    endfunction

    // full chain; w is only kept when no matrix is applied
    function automatic t_point transform_point(input t_point p);
        t_point q;
        int     n;
        q = p;
        n = (chain_len_shadow > NUM_MATS) ? NUM_MATS : int'(chain_len_shadow);
        for (int i = 0; i < n; i++) begin
            t_point nxt;
            for (int r = 0; r < 4; r++)
                nxt[r] = row_result(i, r, q);
            q = nxt;
        end
        return q;
    endfunction

    // ------------------------------------------------------------------
    // value pickers
    // ------------------------------------------------------------------
    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // mostly within +-0.75 so long chains do not always saturate
    function automatic logic [31:0] pick_element();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return pick_extreme();
            default: return int'($urandom_range(0, 98304)) - 49152;
        endcase
    endfunction

    // mostly within +-64.0
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return pick_extreme();
            default: return int'($urandom_range(0, 1 << 23)) - (1 << 22);
        endcase
    endfunction

    function automatic t_point random_point();
        t_point p;
        for (int k = 0; k < 4; k++)
            p[k] = pick_coord();
        return p;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic log_mismatch(input string msg);
        if (mismatch_count < 30)
            $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    // result monitor, compares against the oldest pending point
    always @(posedge clk) begin : check_results
        t_point want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_points.size() == 0) begin
                log_mismatch($sformatf("result with nothing pending: %h", m_tdata));
            end else begin
                want = pending_points.pop_front();
                for (int f = 0; f < 4; f++) begin
                    if (m_tdata[f*COORD_W +: COORD_W] !== want[f])
                        log_mismatch($sformatf("result %0d q%c: got %h want %h",
                            results_checked, field_tag[f],
                            m_tdata[f*COORD_W +: COORD_W], want[f]));
                end
                results_checked++;
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("ERROR: timeout after %0d cycles, %0d results pending",
                cycle_count, pending_points.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // result side: changing stall pattern, plus a long hold on request
    // ------------------------------------------------------------------
    int hold_seen    = 0;
    int hold_left    = 0;
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int rx_tick      = 0;

    always @(posedge clk) begin
        rx_tick <= rx_tick + 1;
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(50, 300);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rx_tick % 5 != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // offer one request in bursts with random gaps; update shadow on accept
    task automatic send_request(input logic func, input logic [2:0] mat,
                                input logic [1:0] row, input logic [1:0] col,
                                input logic [31:0] elem, input t_point pt);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {1'b0, pt[3], pt[2], pt[1], pt[0], elem, col, row, mat};
        do @(posedge clk); while (!s_tready);
        if (func == FUNC_WRITE) begin
            matrix_shadow[mat][row][col] = elem;
            writes_sent++;
        end else begin
            pending_points.push_back(transform_point(pt));
            points_sent++;
        end
    endtask

    // point fields carry noise on a write request
    task automatic send_write(input int mat, input int row, input int col,
                              input logic [31:0] elem);
        send_request(FUNC_WRITE, mat[2:0], row[1:0], col[1:0], elem, random_point());
    endtask

    // write fields carry noise on a point request
    task automatic send_point(input t_point pt);
        send_request(FUNC_POINT, 3'($urandom), 2'($urandom), 2'($urandom), $urandom, pt);
    endtask

    // drop valid, let all results and any trailing write finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_chain_length(input logic [CFG_W-1:0] n);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we    <= 1'b0;
        chain_len_shadow = n;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // empty chain: points come back untouched, w included
    task automatic test_empty_chain();
        set_chain_length(4'd0);
        send_point({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        send_point({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        send_point({32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000});
        send_point({32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)});
        send_point(random_point());
    endtask

    // fill every element of every matrix; matrix 0 is the identity
    task automatic test_matrix_load();
        for (int m = 0; m < NUM_MATS; m++)
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    send_write(m, r, c, (m == 0) ? ((r == c) ? 32'h0001_0000 : 32'h0)
                                                 : pick_element());
    endtask

    // identity pass: x, y, z return, w becomes 1.0
    task automatic test_identity_extremes();
        set_chain_length(4'd1);
        send_point({32'h1234_5678, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
        send_point({32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
        send_point(random_point());
    endtask

    // floor on a half, and saturation both ways
    task automatic test_rounding_saturation();
        send_write(0, 0, 0, 32'h0000_8000);
        send_write(0, 1, 1, 32'h7FFF_FFFF);
        send_write(0, 1, 3, 32'h7FFF_FFFF);
        send_write(0, 2, 2, 32'h8000_0000);
        send_point({32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001});
        send_point({32'h0, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF});
        send_point({32'h0, 32'h0000_0003, 32'hFFFF_FFFD, 32'h0001_0001});
    endtask

    // full chain, and a length above the store size that gets capped
    task automatic test_long_chain_cap();
        set_chain_length(4'd8);
        send_point(random_point());
        set_chain_length(4'd15);
        send_point(random_point());
    endtask

    // long hold on the result side while points keep coming
    task automatic test_output_backpressure();
        set_chain_length(4'd1);
        hold_seq <= hold_seq + 1;
        repeat (12) send_point(random_point());
    endtask

    // random phases: new chain length each phase, mixed writes and points
    task automatic test_random_traffic();
        int sent;
        int phase;
        int phase_len;
        int write_pct;
        logic [CFG_W-1:0] n;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0:       n = 4'd8;
                1:       n = 4'd0;
                2:       n = 4'd15;
                3:       n = 4'd1;
                default: n = 4'($urandom_range(0, 15));
            endcase
            set_chain_length(n);
            phase_len = $urandom_range(60, 120);
            write_pct = $urandom_range(10, 50);
            for (int i = 0; i < phase_len; i++) begin
                if ($urandom_range(1, 100) <= write_pct)
                    send_write($urandom_range(0, NUM_MATS - 1), $urandom_range(0, 3),
                               $urandom_range(0, 3), pick_element());
                else
                    send_point(random_point());
            end
            sent += phase_len;
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_chain();
        test_matrix_load();
        test_identity_extremes();
        test_rounding_saturation();
        test_long_chain_cap();
        test_output_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (END_CYCLES) @(posedge clk);

        $display("Run covered %0d element writes and %0d points, %0d results compared,",
            writes_sent, points_sent, results_checked);
        $display("over chain lengths 0 to 15 with floor rounding and saturation cases.");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
